@@ rtl/core/quadrature_tone_chirp_generator_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the quadrature tone chirp generator
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_TONE_CHIRP_GENERATOR_DEFINES_SVH
`define QUADRATURE_TONE_CHIRP_GENERATOR_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define QTCG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define QTCG_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/qtcg_pkg.sv @@
// ----------------------------------------------------------------------------
// qtcg_pkg
// Types and constants shared by the quadrature tone chirp generator.
// ----------------------------------------------------------------------------
package qtcg_pkg;

  typedef enum logic [1:0] {
    REG_START_STEP    = 2'd0,
    REG_SWEEP_DELTA   = 2'd1,
    REG_SWEEP_ENABLE  = 2'd2,
    REG_SAMPLE_FORMAT = 2'd3
  } cfg_reg_e;

  localparam logic [1:0] FMT_16BIT = 2'd0;
  localparam logic [1:0] FMT_8BIT  = 2'd1;
  localparam logic [1:0] FMT_4BIT  = 2'd2;
  localparam logic [1:0] FMT_SPARE = 2'd3;

  localparam int AMP_BITS = 15;
  localparam logic [AMP_BITS-1:0] AMP_16BIT = 15'd32766;
  localparam logic [AMP_BITS-1:0] AMP_8BIT  = 15'd126;
  localparam logic [AMP_BITS-1:0] AMP_4BIT  = 15'd7;

  localparam logic [2:0] COUNT_16BIT = 3'd4;
  localparam logic [2:0] COUNT_8BIT  = 3'd2;
  localparam logic [2:0] COUNT_4BIT  = 3'd1;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic signed [31:0] start_step;
    logic signed [31:0] sweep_delta;
    logic               sweep_enable;
  } sweep_cfg_t;

endpackage

@@ rtl/core/qtcg_front.sv @@
// ----------------------------------------------------------------------------
// qtcg_front
// Accepts sample ticks, applies restarts and advances phase and step.
// ----------------------------------------------------------------------------
`include "quadrature_tone_chirp_generator_defines.svh"

module qtcg_front #(
  parameter int PHASE_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  qtcg_pkg::sweep_cfg_t   cfg_i,
  input  logic                   in_valid_i,
  input  logic                   queue_ready_i,
  input  logic                   restart_i,
  output logic                   push_o,
  output logic [PHASE_BITS-1:0]  phase_o
);

  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic [PHASE_BITS-1:0] step_q, step_d;
  logic [PHASE_BITS-1:0] phase_cur, step_cur;
  logic [PHASE_BITS-1:0] start_w, delta_w;
  logic                  accept;

  assign accept  = in_valid_i && queue_ready_i;
  assign start_w = PHASE_BITS'(cfg_i.start_step);
  assign delta_w = PHASE_BITS'(cfg_i.sweep_delta);

  always_comb begin
    phase_cur = restart_i ? '0 : phase_q;
    step_cur  = restart_i ? start_w : step_q;
    phase_d   = phase_q;
    step_d    = step_q;
    if (accept) begin
      phase_d = phase_cur + step_cur;
      step_d  = cfg_i.sweep_enable ? step_cur + delta_w : step_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      step_q  <= '0;
    end else begin
      phase_q <= phase_d;
      step_q  <= step_d;
    end
  end

  assign push_o  = accept;
  assign phase_o = phase_cur;

  `QTCG_ASSERT_NEXT(a_restart_phase, accept && restart_i, phase_q == $past(step_cur),
                    "phase after a restart is not the start step")

endmodule

@@ rtl/core/qtcg_fifo.sv @@
// ----------------------------------------------------------------------------
// qtcg_fifo
// Short queue of phase values between the front and the back.
// ----------------------------------------------------------------------------
`include "quadrature_tone_chirp_generator_defines.svh"

module qtcg_fifo #(
  parameter int WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] head_o
);

  localparam int Depth   = qtcg_pkg::QUEUE_DEPTH;
  localparam int PtrBits = $clog2(Depth);
  localparam int CntBits = $clog2(Depth + 1);

  logic [WIDTH-1:0]   mem_q [Depth];
  logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0] count_q;

  assign ready_o = count_q != CntBits'(Depth);
  assign empty_o = count_q == '0;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `QTCG_ASSERT(a_count_bound, count_q <= CntBits'(Depth), "queue count exceeds depth")
  `QTCG_ASSERT(a_no_pop_empty, !(pop_i && empty_o), "pop from an empty queue")

endmodule

@@ rtl/core/qtcg_back.sv @@
// ----------------------------------------------------------------------------
// qtcg_back
// Looks up sine and cosine, scales them and packs the output bytes.
// ----------------------------------------------------------------------------
`include "quadrature_tone_chirp_generator_defines.svh"

module qtcg_back #(
  parameter int TABLE_ADDR_BITS = 10,
  parameter int TABLE_FRAC_BITS = 17,
  parameter int PHASE_BITS      = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [1:0]            sample_format_i,
  input  logic                  empty_i,
  input  logic [PHASE_BITS-1:0] head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [15:0]           i_sample_o,
  output logic [15:0]           q_sample_o,
  output logic [31:0]           packed_word_o,
  output logic [2:0]            byte_count_o
);

  localparam int A        = TABLE_ADDR_BITS;
  localparam int F        = TABLE_FRAC_BITS;
  localparam int Size     = 1 << A;
  localparam int ProdBits = F + 1 + qtcg_pkg::AMP_BITS;

  typedef logic [F:0] rom_t [Size];

  function automatic rom_t build_rom();
    rom_t        r;
    logic [63:0] x, x2, t, s;
    for (int k = 0; k < Size; k++) begin
      x  = (64'd1686629713 * 64'(k) + (64'd1 << (A - 1))) >> A;
      x2 = (x * x) >> 30;
      t  = 64'd1 << 30;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd156;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd110;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd72;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd42;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd20;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      r[k] = (F + 1)'((s + (64'd1 << (29 - F))) >> (30 - F));
    end
    return r;
  endfunction

  localparam rom_t SineRom = build_rom();

  logic          adv;
  logic [A+1:0]  top;
  logic [A-1:0]  addr_a, addr_b;
  logic [1:0]    quad;

  logic          v1_q, v2_q, out_valid_q;
  logic [F:0]    rom_a_q, rom_b_q;
  logic          odd_q, kzero_q, neg_i1_q, neg_q1_q;
  logic [F:0]    mag_i, mag_q;
  logic [qtcg_pkg::AMP_BITS-1:0] amp;
  logic [ProdBits-1:0] prod_i, prod_q;
  logic [15:0]   sc_i_q, sc_q_q;
  logic          neg_i2_q, neg_q2_q;
  logic [15:0]   iu, qu;
  logic [31:0]   word;
  logic [2:0]    count;

  logic [15:0]   i_out_q, q_out_q;
  logic [31:0]   word_q;
  logic [2:0]    count_q;

  assign adv    = !out_valid_q || out_ready_i;
  assign pop_o  = adv && !empty_i;
  assign top    = head_i[PHASE_BITS-1 -: A + 2];
  assign quad   = top[A+1:A];
  assign addr_a = top[A-1:0];
  assign addr_b = -top[A-1:0];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rom_a_q  <= SineRom[addr_a];
      rom_b_q  <= SineRom[addr_b];
      odd_q    <= quad[0];
      kzero_q  <= addr_a == '0;
      neg_i1_q <= quad[1];
      neg_q1_q <= quad[1] ^ quad[0];
    end
  end

  always_comb begin
    case (sample_format_i)
      qtcg_pkg::FMT_8BIT: amp = qtcg_pkg::AMP_8BIT;
      qtcg_pkg::FMT_4BIT: amp = qtcg_pkg::AMP_4BIT;
      default:            amp = qtcg_pkg::AMP_16BIT;
    endcase
    if (odd_q) begin
      mag_i = kzero_q ? (F + 1)'(1) << F : rom_b_q;
      mag_q = rom_a_q;
    end else begin
      mag_i = rom_a_q;
      mag_q = kzero_q ? (F + 1)'(1) << F : rom_b_q;
    end
    prod_i = ProdBits'(mag_i) * ProdBits'(amp);
    prod_q = ProdBits'(mag_q) * ProdBits'(amp);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sc_i_q   <= 16'(prod_i >> F);
      sc_q_q   <= 16'(prod_q >> F);
      neg_i2_q <= neg_i1_q;
      neg_q2_q <= neg_q1_q;
    end
  end

  always_comb begin
    iu = neg_i2_q ? -sc_i_q : sc_i_q;
    qu = neg_q2_q ? -sc_q_q : sc_q_q;
    case (sample_format_i)
      qtcg_pkg::FMT_8BIT: begin
        word  = {16'd0, qu[7:0], iu[7:0]};
        count = qtcg_pkg::COUNT_8BIT;
      end
      qtcg_pkg::FMT_4BIT: begin
        word  = {24'd0, iu[3:0], qu[3:0]};
        count = qtcg_pkg::COUNT_4BIT;
      end
      default: begin
        word  = {qu[7:0], qu[15:8], iu[7:0], iu[15:8]};
        count = qtcg_pkg::COUNT_16BIT;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv && v2_q) begin
      i_out_q <= iu;
      q_out_q <= qu;
      word_q  <= word;
      count_q <= count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= !empty_i;
      v2_q        <= v1_q;
      out_valid_q <= v2_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign i_sample_o    = i_out_q;
  assign q_sample_o    = q_out_q;
  assign packed_word_o = word_q;
  assign byte_count_o  = count_q;

  `QTCG_ASSERT_NEXT(a_stage_to_out, v2_q && adv, out_valid_q,
                    "a scaled sample did not reach the output register")

endmodule

@@ rtl/core/quadrature_tone_chirp_generator.sv @@
// ----------------------------------------------------------------------------
// quadrature_tone_chirp_generator
// Quadrature NCO with optional linear chirp: one I/Q result per sample tick.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_axis    in         tdata[0] restart
//  m_axis    out        i_sample, q_sample, packed_word, byte_count
//  cfg       in         write enable, register index, 32-bit data
//
// One transaction is accepted per cycle while the queue has room; the phase
// accumulator closes its loop through one register. A sample passes the queue,
// ROM read, scaling multiply and output register. A stalled output freezes the
// back pipeline and the four-entry queue then fills before s_axis_tready drops.
// Reset clears phase, step, config, queue pointers and valid flags.
// ----------------------------------------------------------------------------
module quadrature_tone_chirp_generator #(
  parameter int TABLE_ADDR_BITS = 10,
  parameter int TABLE_FRAC_BITS = 17,
  parameter int PHASE_BITS      = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] restart, [7:1] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [15:0] i_sample, [31:16] q_sample,
                                      // [63:32] packed_word, [66:64] byte_count
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  qtcg_pkg::sweep_cfg_t cfg_q;
  logic [1:0]            fmt_q;

  logic                  push, pop, q_ready, q_empty;
  logic [PHASE_BITS-1:0] push_phase, head_phase;
  logic [15:0]           i_sample, q_sample;
  logic [31:0]           packed_word;
  logic [2:0]            byte_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
      fmt_q <= qtcg_pkg::FMT_16BIT;
    end else if (cfg_we_i) begin
      case (qtcg_pkg::cfg_reg_e'(cfg_idx_i))
        qtcg_pkg::REG_START_STEP:    cfg_q.start_step   <= cfg_data_i;
        qtcg_pkg::REG_SWEEP_DELTA:   cfg_q.sweep_delta  <= cfg_data_i;
        qtcg_pkg::REG_SWEEP_ENABLE:  cfg_q.sweep_enable <= cfg_data_i[0];
        qtcg_pkg::REG_SAMPLE_FORMAT: fmt_q              <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  qtcg_front #(
    .PHASE_BITS(PHASE_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (s_axis_tvalid),
    .queue_ready_i (q_ready),
    .restart_i     (s_axis_tdata[0]),
    .push_o        (push),
    .phase_o       (push_phase)
  );

  qtcg_fifo #(
    .WIDTH(PHASE_BITS)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_phase),
    .ready_o     (q_ready),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (head_phase)
  );

  qtcg_back #(
    .TABLE_ADDR_BITS(TABLE_ADDR_BITS),
    .TABLE_FRAC_BITS(TABLE_FRAC_BITS),
    .PHASE_BITS     (PHASE_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .sample_format_i (fmt_q),
    .empty_i         (q_empty),
    .head_i          (head_phase),
    .pop_o           (pop),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .i_sample_o      (i_sample),
    .q_sample_o      (q_sample),
    .packed_word_o   (packed_word),
    .byte_count_o    (byte_count)
  );

  assign s_axis_tready = q_ready;
  assign m_axis_tdata  = {5'd0, byte_count, packed_word, q_sample, i_sample};

endmodule
